/* rtl/tac_pkg.sv */
package tac_pkg;

    localparam int CAL_SAMPLES_DEF     = 100;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // CORDIC datapath: angles in 2^-20 degree, vectors scaled by 2^16.
    localparam int ZBITS         = 20;
    localparam int XSCALE        = 16;
    localparam int XW            = 36;
    localparam int ZW            = 32;
    localparam int TW            = 27;
    localparam int CORDIC_STEPS  = 24;
    localparam int STAGE_STEPS   = 3;
    localparam int CORDIC_STAGES = CORDIC_STEPS / STAGE_STEPS;

    localparam logic [2:0] FN_SAMPLE  = 3'd0;
    localparam logic [2:0] FN_SET_REF = 3'd1;
    localparam logic [2:0] FN_CLR_REF = 3'd2;
    localparam logic [2:0] FN_SET_ADJ = 3'd3;
    localparam logic [2:0] FN_CLR_ADJ = 3'd4;

    localparam logic [2:0] KD_ANGLE   = 3'd0;
    localparam logic [2:0] KD_REF_SET = 3'd1;
    localparam logic [2:0] KD_REF_CLR = 3'd2;
    localparam logic [2:0] KD_ADJ_SET = 3'd3;
    localparam logic [2:0] KD_ADJ_CLR = 3'd4;
    localparam logic [2:0] KD_ERROR   = 3'd5;

    // Degenerate input vectors that skip the CORDIC result.
    localparam logic [2:0] SP_NONE = 3'd0;
    localparam logic [2:0] SP_ZERO = 3'd1;
    localparam logic [2:0] SP_180  = 3'd2;
    localparam logic [2:0] SP_P90  = 3'd3;
    localparam logic [2:0] SP_N90  = 3'd4;

    localparam logic [1:0] TG_IDLE = 2'd0;
    localparam logic [1:0] TG_REF  = 2'd1;
    localparam logic [1:0] TG_ADJ  = 2'd2;

    typedef struct packed {
        logic       vld;
        logic [2:0] func;
        logic [2:0] spx;
        logic [2:0] spy;
    } t_ctl;

    function automatic logic signed [TW-1:0] atan_entry(input logic [4:0] i);
        logic signed [TW-1:0] v;
        case (i)
            5'd0:    v = 27'sd47185920;
            5'd1:    v = 27'sd27855475;
            5'd2:    v = 27'sd14718068;
            5'd3:    v = 27'sd7471121;
            5'd4:    v = 27'sd3750058;
            5'd5:    v = 27'sd1876857;
            5'd6:    v = 27'sd938658;
            5'd7:    v = 27'sd469357;
            5'd8:    v = 27'sd234682;
            5'd9:    v = 27'sd117342;
            5'd10:   v = 27'sd58671;
            5'd11:   v = 27'sd29335;
            5'd12:   v = 27'sd14668;
            5'd13:   v = 27'sd7334;
            5'd14:   v = 27'sd3667;
            5'd15:   v = 27'sd1833;
            5'd16:   v = 27'sd917;
            5'd17:   v = 27'sd458;
            5'd18:   v = 27'sd229;
            5'd19:   v = 27'sd115;
            5'd20:   v = 27'sd57;
            5'd21:   v = 27'sd29;
            5'd22:   v = 27'sd14;
            5'd23:   v = 27'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/tac_if.sv */
interface tac_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, output func, output acc_x, output acc_y, output acc_z,
                    input ready);
    modport sink (input valid, input func, input acc_x, input acc_y, input acc_z,
                  output ready);
endinterface

interface tac_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [18:0] angle_x_rel;
    logic signed [18:0] angle_y_rel;

    modport source (output valid, output kind, output angle_x_rel, output angle_y_rel,
                    input ready);
    modport sink (input valid, input kind, input angle_x_rel, input angle_y_rel,
                  output ready);
endinterface

/* rtl/tilt_angle_with_calibration.sv */
// Tilt angles of a three-axis accelerometer with zero-adjust and reference
// offsets. Each sample word yields the X angle atan2(ay, az+|ax|) and the Y angle
// -atan2(ax, az+|ay|) in 1/2^ANGLE_FRAC_BITS degree, minus both offsets. A set
// command averages the next CAL_SAMPLES sample angles into the chosen offset and
// reports once when done; samples during calibration give no result word.
// The block takes one word per cycle while the output is not stalled. A word's
// result passes the pipelined 24-step CORDIC (eight stages of three steps) and the
// reciprocal-multiply averaging stages before the output register. A stalled output
// stalls the whole pipeline.
module tilt_angle_with_calibration
    import tac_pkg::*;
#(
    parameter int CAL_SAMPLES     = CAL_SAMPLES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tac_in_if.sink    i_in,
    tac_out_if.source o_out
);

    localparam int CLOG_C = $clog2(CAL_SAMPLES);
    localparam int ANG_W  = ANGLE_FRAC_BITS + 10;
    localparam int SUM_W  = CLOG_C + ANGLE_FRAC_BITS + 9;
    localparam int CW     = $clog2(CAL_SAMPLES + 1);
    localparam int MW     = SUM_W;
    localparam int SH     = MW + CLOG_C;
    localparam int RW     = MW + 1;
    localparam int PW     = MW + RW;
    localparam int SW     = MW + 18;
    localparam int DW     = ((ANG_W > 17) ? ANG_W : 17) + 2;
    localparam int RS     = ZBITS - ANGLE_FRAC_BITS;

    localparam logic [RW-1:0] RECIP  = RW'((64'd1 << SH) / CAL_SAMPLES);
    localparam logic [MW-1:0] HALF_C = MW'(CAL_SAMPLES / 2);
    localparam logic signed [ZW-1:0]    RND     = ZW'(1) << (RS - 1);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180) << ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90) << ANGLE_FRAC_BITS;
    localparam logic signed [SW-1:0]    OFF_MAX = SW'(65535);
    localparam logic signed [SW-1:0]    OFF_MIN = SW'(-65536);
    localparam logic signed [DW-1:0]    OUT_MAX = DW'(262143);
    localparam logic signed [DW-1:0]    OUT_MIN = DW'(-262144);

    function automatic void prep(input logic signed [17:0] xi, input logic signed [15:0] yi,
                                 output logic [2:0] sp, output logic signed [XW-1:0] xo,
                                 output logic signed [XW-1:0] yo,
                                 output logic signed [ZW-1:0] zo);
        logic signed [17:0] xa, ya;
        xa = xi;
        ya = 18'(yi);
        zo = '0;
        if (yi == 16'sd0) begin
            sp = xi[17] ? SP_180 : SP_ZERO;
        end else if (xi == 18'sd0) begin
            sp = yi[15] ? SP_N90 : SP_P90;
        end else begin
            sp = SP_NONE;
        end
        // Left half plane: mirror through the origin and start from +/-180.
        if (xi[17]) begin
            zo = yi[15] ? -(ZW'(180) << ZBITS) : (ZW'(180) << ZBITS);
            xa = -xa;
            ya = -ya;
        end
        xo = XW'(xa) <<< XSCALE;
        yo = XW'(ya) <<< XSCALE;
    endfunction

    function automatic logic signed [ANG_W-1:0] finish(input logic [2:0] sp,
                                                       input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0]    t;
        logic signed [ANG_W-1:0] v;
        t = (z + RND) >>> RS;
        case (sp)
            SP_ZERO: v = '0;
            SP_180:  v = ANG_180;
            SP_P90:  v = ANG_90;
            SP_N90:  v = -ANG_90;
            default: v = t[ANG_W-1:0];
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] avg(input logic neg, input logic [MW-1:0] m,
                                               input logic [MW-1:0] q);
        logic [MW:0]          qc, r, q2;
        logic signed [SW-1:0] sq;
        qc = (MW + 1)'(q) * (MW + 1)'(CAL_SAMPLES);
        r  = (MW + 1)'(m) - qc;
        q2 = (MW + 1)'(q) + ((r >= (MW + 1)'(CAL_SAMPLES)) ? (MW + 1)'(1) : '0);
        sq = neg ? -SW'(q2) : SW'(q2);
        if (sq > OFF_MAX) begin
            sq = OFF_MAX;
        end else if (sq < OFF_MIN) begin
            sq = OFF_MIN;
        end
        return sq[16:0];
    endfunction

    function automatic logic signed [18:0] rel(input logic signed [ANG_W-1:0] a,
                                               input logic signed [16:0] adj,
                                               input logic signed [16:0] rf);
        logic signed [DW-1:0] d;
        d = DW'(a) - DW'(adj) - DW'(rf);
        if (d > OUT_MAX) begin
            d = OUT_MAX;
        end else if (d < OUT_MIN) begin
            d = OUT_MIN;
        end
        return d[18:0];
    endfunction

    logic w_adv;
    logic r_o_vld;

    assign w_adv      = !r_o_vld || o_out.ready;
    assign i_in.ready = w_adv;

    // Input register.
    logic               r0_vld;
    logic [2:0]         r0_func;
    logic signed [15:0] r0_ax, r0_ay, r0_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_adv) begin
            r0_vld <= i_in.valid;
        end
        if (w_adv) begin
            r0_func <= i_in.func;
            r0_ax   <= i_in.acc_x;
            r0_ay   <= i_in.acc_y;
            r0_az   <= i_in.acc_z;
        end
    end

    // Vector setup for both angles.
    logic signed [17:0]   w_ax18, w_ay18, w_xin_x, w_xin_y;
    logic [2:0]           w_spx, w_spy;
    logic signed [XW-1:0] w_px_x, w_px_y, w_py_x, w_py_y;
    logic signed [ZW-1:0] w_px_z, w_py_z;

    always_comb begin
        w_ax18  = 18'(r0_ax);
        w_ay18  = 18'(r0_ay);
        w_xin_x = 18'(r0_az) + (w_ax18[17] ? -w_ax18 : w_ax18);
        w_xin_y = 18'(r0_az) + (w_ay18[17] ? -w_ay18 : w_ay18);
        prep(w_xin_x, r0_ay, w_spx, w_px_x, w_px_y, w_px_z);
        prep(w_xin_y, r0_ax, w_spy, w_py_x, w_py_y, w_py_z);
    end

    t_ctl                 r_ctl [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_xx [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_xy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_xz [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_yx [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_yy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_yz [CORDIC_STAGES+1];
    logic signed [XW-1:0] r_p_xx, r_p_xy, r_p_yx, r_p_yy;
    logic signed [ZW-1:0] r_p_xz, r_p_yz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (w_adv) begin
            r_ctl[0] <= '{vld: r0_vld, func: r0_func, spx: w_spx, spy: w_spy};
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
        if (w_adv) begin
            r_p_xx <= w_px_x;
            r_p_xy <= w_px_y;
            r_p_xz <= w_px_z;
            r_p_yx <= w_py_x;
            r_p_yy <= w_py_y;
            r_p_yz <= w_py_z;
        end
    end

    assign w_xx[0] = r_p_xx;
    assign w_xy[0] = r_p_xy;
    assign w_xz[0] = r_p_xz;
    assign w_yx[0] = r_p_yx;
    assign w_yy[0] = r_p_yy;
    assign w_yz[0] = r_p_yz;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        tac_cordic_stage u_ax (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_step0 (5'(g * STAGE_STEPS)),
            .i_x     (w_xx[g]),
            .i_y     (w_xy[g]),
            .i_z     (w_xz[g]),
            .o_x     (w_xx[g+1]),
            .o_y     (w_xy[g+1]),
            .o_z     (w_xz[g+1])
        );
        tac_cordic_stage u_ay (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_step0 (5'(g * STAGE_STEPS)),
            .i_x     (w_yx[g]),
            .i_y     (w_yy[g]),
            .i_z     (w_yz[g]),
            .o_x     (w_yx[g+1]),
            .o_y     (w_yy[g+1]),
            .o_z     (w_yz[g+1])
        );
    end

    // Rounded raw angles.
    logic                    r_f_vld;
    logic [2:0]              r_f_func;
    logic signed [ANG_W-1:0] r_f_angx, r_f_angy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= r_ctl[CORDIC_STAGES].vld;
        end
        if (w_adv) begin
            r_f_func <= r_ctl[CORDIC_STAGES].func;
            r_f_angx <= finish(r_ctl[CORDIC_STAGES].spx, w_xz[CORDIC_STAGES]);
            r_f_angy <= -finish(r_ctl[CORDIC_STAGES].spy, w_yz[CORDIC_STAGES]);
        end
    end

    // Command decode and calibration accumulation.
    logic [1:0]              r_tgt, n_tgt;
    logic [CW-1:0]           r_cnt, n_cnt, w_cnt1;
    logic signed [SUM_W-1:0] r_sx, r_sy, n_sx, n_sy, w_acc_x, w_acc_y;
    logic                    u_emit;
    logic [2:0]              u_kind;

    always_comb begin
        n_tgt   = r_tgt;
        n_cnt   = r_cnt;
        n_sx    = r_sx;
        n_sy    = r_sy;
        u_emit  = 1'b0;
        u_kind  = KD_ERROR;
        w_cnt1  = r_cnt + CW'(1);
        w_acc_x = r_sx + SUM_W'(r_f_angx);
        w_acc_y = r_sy + SUM_W'(r_f_angy);
        if (r_f_vld) begin
            unique case (r_f_func) inside
                FN_SAMPLE: begin
                    if (r_tgt != TG_IDLE) begin
                        if (w_cnt1 == CW'(CAL_SAMPLES)) begin
                            u_emit = 1'b1;
                            u_kind = (r_tgt == TG_REF) ? KD_REF_SET : KD_ADJ_SET;
                            n_tgt  = TG_IDLE;
                            n_cnt  = '0;
                            n_sx   = '0;
                            n_sy   = '0;
                        end else begin
                            n_cnt = w_cnt1;
                            n_sx  = w_acc_x;
                            n_sy  = w_acc_y;
                        end
                    end else begin
                        u_emit = 1'b1;
                        u_kind = KD_ANGLE;
                    end
                end
                FN_SET_REF, FN_SET_ADJ: begin
                    n_tgt = (r_f_func == FN_SET_REF) ? TG_REF : TG_ADJ;
                    n_cnt = '0;
                    n_sx  = '0;
                    n_sy  = '0;
                end
                FN_CLR_REF: begin
                    u_emit = 1'b1;
                    u_kind = KD_REF_CLR;
                end
                FN_CLR_ADJ: begin
                    u_emit = 1'b1;
                    u_kind = KD_ADJ_CLR;
                end
                default: begin
                    u_emit = 1'b1;
                    u_kind = KD_ERROR;
                end
            endcase
        end
    end

    logic                    r_u_vld;
    logic [2:0]              r_u_kind;
    logic signed [ANG_W-1:0] r_u_angx, r_u_angy;
    logic signed [SUM_W-1:0] r_u_sx, r_u_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt   <= TG_IDLE;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_u_vld <= 1'b0;
        end else if (w_adv) begin
            r_tgt   <= n_tgt;
            r_cnt   <= n_cnt;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_u_vld <= u_emit;
        end
        if (w_adv) begin
            r_u_kind <= u_kind;
            r_u_angx <= r_f_angx;
            r_u_angy <= r_f_angy;
            r_u_sx   <= w_acc_x;
            r_u_sy   <= w_acc_y;
        end
    end

    // Averaging, step one: quotient estimate by reciprocal multiply.
    logic [MW-1:0] w_mx, w_my;
    logic [PW-1:0] w_prx, w_pry;

    always_comb begin
        w_mx  = MW'(r_u_sx[SUM_W-1] ? -r_u_sx : r_u_sx) + HALF_C;
        w_my  = MW'(r_u_sy[SUM_W-1] ? -r_u_sy : r_u_sy) + HALF_C;
        w_prx = PW'(w_mx) * PW'(RECIP);
        w_pry = PW'(w_my) * PW'(RECIP);
    end

    logic                    r_d_vld;
    logic [2:0]              r_d_kind;
    logic signed [ANG_W-1:0] r_d_angx, r_d_angy;
    logic                    r_d_negx, r_d_negy;
    logic [MW-1:0]           r_d_mx, r_d_my, r_d_qx, r_d_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_u_vld;
        end
        if (w_adv) begin
            r_d_kind <= r_u_kind;
            r_d_angx <= r_u_angx;
            r_d_angy <= r_u_angy;
            r_d_negx <= r_u_sx[SUM_W-1];
            r_d_negy <= r_u_sy[SUM_W-1];
            r_d_mx   <= w_mx;
            r_d_my   <= w_my;
            r_d_qx   <= MW'(w_prx >> SH);
            r_d_qy   <= MW'(w_pry >> SH);
        end
    end

    // Averaging, step two: one correction, then the offset update.
    logic signed [16:0] r_ref_x, r_ref_y, r_adj_x, r_adj_y;
    logic signed [16:0] w_avx, w_avy;

    assign w_avx = avg(r_d_negx, r_d_mx, r_d_qx);
    assign w_avy = avg(r_d_negy, r_d_my, r_d_qy);

    logic                    r_e_vld;
    logic [2:0]              r_e_kind;
    logic signed [ANG_W-1:0] r_e_angx, r_e_angy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_adj_x <= '0;
            r_adj_y <= '0;
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_d_vld;
            if (r_d_vld) begin
                case (r_d_kind)
                    KD_REF_SET: begin
                        r_ref_x <= w_avx;
                        r_ref_y <= w_avy;
                    end
                    KD_ADJ_SET: begin
                        r_adj_x <= w_avx;
                        r_adj_y <= w_avy;
                    end
                    KD_REF_CLR: begin
                        r_ref_x <= '0;
                        r_ref_y <= '0;
                    end
                    KD_ADJ_CLR: begin
                        r_adj_x <= '0;
                        r_adj_y <= '0;
                    end
                    default: ;
                endcase
            end
        end
        if (w_adv) begin
            r_e_kind <= r_d_kind;
            r_e_angx <= r_d_angx;
            r_e_angy <= r_d_angy;
        end
    end

    // Output register: offsets here already include every earlier word's update.
    logic [2:0]         r_o_kind;
    logic signed [18:0] r_o_ax, r_o_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_e_vld;
        end
        if (w_adv) begin
            r_o_kind <= r_e_kind;
            r_o_ax   <= (r_e_kind == KD_ANGLE) ? rel(r_e_angx, r_adj_x, r_ref_x) : '0;
            r_o_ay   <= (r_e_kind == KD_ANGLE) ? rel(r_e_angy, r_adj_y, r_ref_y) : '0;
        end
    end

    assign o_out.valid       = r_o_vld;
    assign o_out.kind        = r_o_kind;
    assign o_out.angle_x_rel = r_o_ax;
    assign o_out.angle_y_rel = r_o_ay;

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_kind != KD_ANGLE) |-> (r_o_ax == '0 && r_o_ay == '0))
        else $error("status word carries nonzero angles");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(CAL_SAMPLES))
        else $error("calibration count reached its limit without finishing");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tgt == TG_IDLE) |-> (r_cnt == '0 && r_sx == '0 && r_sy == '0))
        else $error("calibration sums left over while idle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !o_out.ready) |=> ($stable(r_ref_x) && $stable(r_adj_x) &&
                                       $stable(r_tgt) && $stable(r_cnt)))
        else $error("state changed while the output was stalled");

endmodule

/* rtl/tac_cordic_stage.sv */
module tac_cordic_stage
    import tac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [4:0]           i_step0,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    always_comb begin
        logic signed [XW-1:0] xs, ys;
        logic [4:0]           idx;
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        for (int k = 0; k < STAGE_STEPS; k++) begin
            idx = i_step0 + 5'(k);
            xs  = n_x >>> idx;
            ys  = n_y >>> idx;
            // Rotate toward the positive x axis, accumulating the angle.
            if (n_y[XW-1]) begin
                n_x = n_x - ys;
                n_y = n_y + xs;
                n_z = n_z - ZW'(atan_entry(idx));
            end else begin
                n_x = n_x + ys;
                n_y = n_y - xs;
                n_z = n_z + ZW'(atan_entry(idx));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
